// ----- rtl/core/arae_pkg.sv -----
// ============================================================================
// arae_pkg: shared types, relocation codes and addend decode
// Holds the ARM ELF relocation type numbers that carry an implicit addend,
// the result type of one decode, and the decode function itself.
// ============================================================================
package arae_pkg;

    // Field widths of one request and one result.
    localparam int unsigned KIND_W   = 8;
    localparam int unsigned WORD_W   = 32;
    localparam int unsigned ADDEND_W = 32;

    typedef logic [KIND_W-1:0] kind_t;
    typedef logic [WORD_W-1:0] word_t;

    // Relocation type numbers from the ARM ELF ABI.
    localparam kind_t RELOC_PC24              = 8'd1;
    localparam kind_t RELOC_ABS32             = 8'd2;
    localparam kind_t RELOC_REL32             = 8'd3;
    localparam kind_t RELOC_LDR_PC_G0         = 8'd4;
    localparam kind_t RELOC_SBREL32           = 8'd9;
    localparam kind_t RELOC_THM_CALL          = 8'd10;
    localparam kind_t RELOC_THM_PC8           = 8'd11;
    localparam kind_t RELOC_TLS_DTPMOD32      = 8'd17;
    localparam kind_t RELOC_TLS_DTPOFF32      = 8'd18;
    localparam kind_t RELOC_TLS_TPOFF32       = 8'd19;
    localparam kind_t RELOC_GLOB_DAT          = 8'd21;
    localparam kind_t RELOC_RELATIVE          = 8'd23;
    localparam kind_t RELOC_GOTOFF32          = 8'd24;
    localparam kind_t RELOC_BASE_PREL         = 8'd25;
    localparam kind_t RELOC_GOT_BREL          = 8'd26;
    localparam kind_t RELOC_PLT32             = 8'd27;
    localparam kind_t RELOC_CALL              = 8'd28;
    localparam kind_t RELOC_JUMP24            = 8'd29;
    localparam kind_t RELOC_THM_JUMP24        = 8'd30;
    localparam kind_t RELOC_TARGET1           = 8'd38;
    localparam kind_t RELOC_PREL31            = 8'd42;
    localparam kind_t RELOC_MOVW_ABS_NC       = 8'd43;
    localparam kind_t RELOC_MOVT_ABS          = 8'd44;
    localparam kind_t RELOC_MOVW_PREL_NC      = 8'd45;
    localparam kind_t RELOC_MOVT_PREL         = 8'd46;
    localparam kind_t RELOC_THM_MOVW_ABS_NC   = 8'd47;
    localparam kind_t RELOC_THM_MOVT_ABS      = 8'd48;
    localparam kind_t RELOC_THM_MOVW_PREL_NC  = 8'd49;
    localparam kind_t RELOC_THM_MOVT_PREL     = 8'd50;
    localparam kind_t RELOC_THM_JUMP19        = 8'd51;
    localparam kind_t RELOC_THM_ALU_PREL_11_0 = 8'd53;
    localparam kind_t RELOC_THM_PC12          = 8'd54;
    localparam kind_t RELOC_ALU_PC_G0_NC      = 8'd57;
    localparam kind_t RELOC_ALU_PC_G0         = 8'd58;
    localparam kind_t RELOC_ALU_PC_G1_NC      = 8'd59;
    localparam kind_t RELOC_ALU_PC_G1         = 8'd60;
    localparam kind_t RELOC_ALU_PC_G2         = 8'd61;
    localparam kind_t RELOC_LDR_PC_G1         = 8'd62;
    localparam kind_t RELOC_LDR_PC_G2         = 8'd63;
    localparam kind_t RELOC_LDRS_PC_G0        = 8'd64;
    localparam kind_t RELOC_LDRS_PC_G1        = 8'd65;
    localparam kind_t RELOC_LDRS_PC_G2        = 8'd66;
    localparam kind_t RELOC_MOVW_BREL_NC      = 8'd84;
    localparam kind_t RELOC_MOVT_BREL         = 8'd85;
    localparam kind_t RELOC_THM_MOVW_BREL_NC  = 8'd87;
    localparam kind_t RELOC_THM_MOVT_BREL     = 8'd88;
    localparam kind_t RELOC_GOT_PREL          = 8'd96;
    localparam kind_t RELOC_THM_JUMP11        = 8'd102;
    localparam kind_t RELOC_THM_JUMP8         = 8'd103;
    localparam kind_t RELOC_TLS_GD32          = 8'd104;
    localparam kind_t RELOC_TLS_LDM32         = 8'd105;
    localparam kind_t RELOC_TLS_LDO32         = 8'd106;
    localparam kind_t RELOC_TLS_IE32          = 8'd107;
    localparam kind_t RELOC_TLS_LE32          = 8'd108;

    // One decoded result.
    typedef struct packed {
        logic [ADDEND_W-1:0] addend;
        logic                handled;
    } addend_res_t;

    // Pull the implicit addend out of the site word for one relocation type.
    function automatic addend_res_t decode_addend(input kind_t kind, input word_t w);
        logic [15:0]         h0;
        logic [15:0]         h1;
        logic                s;
        logic                i1;
        logic                i2;
        logic [15:0]         imm16;
        logic [31:0]         imm;
        logic [9:0]          pc8;
        addend_res_t         res;
        h0    = w[15:0];
        h1    = w[31:16];
        s     = h0[10];
        i1    = ~(h1[13] ^ s);
        i2    = ~(h1[11] ^ s);
        imm16 = '0;
        imm   = '0;
        pc8   = '0;
        res.addend  = '0;
        res.handled = 1'b1;
        unique case (kind)
            // Data words pass through whole.
            RELOC_ABS32, RELOC_REL32, RELOC_SBREL32, RELOC_TLS_DTPMOD32,
            RELOC_TLS_DTPOFF32, RELOC_TLS_TPOFF32, RELOC_GLOB_DAT,
            RELOC_RELATIVE, RELOC_GOTOFF32, RELOC_BASE_PREL, RELOC_GOT_BREL,
            RELOC_TARGET1, RELOC_GOT_PREL, RELOC_TLS_GD32, RELOC_TLS_LDM32,
            RELOC_TLS_LDO32, RELOC_TLS_IE32, RELOC_TLS_LE32: begin
                res.addend = w;
            end
            // Bit 31 is ignored, bits 30:0 are sign-extended.
            RELOC_PREL31: begin
                res.addend = {w[30], w[30:0]};
            end
            // Arm branch: imm24 times four, signed.
            RELOC_PC24, RELOC_PLT32, RELOC_CALL, RELOC_JUMP24: begin
                res.addend = {{6{w[23]}}, w[23:0], 2'b00};
            end
            RELOC_THM_JUMP8: begin
                res.addend = {{23{h0[7]}}, h0[7:0], 1'b0};
            end
            RELOC_THM_JUMP11: begin
                res.addend = {{20{h0[10]}}, h0[10:0], 1'b0};
            end
            // Conditional Thumb branch: S:J2:J1:imm6:imm11:0.
            RELOC_THM_JUMP19: begin
                res.addend = {{11{s}}, s, h1[11], h1[13], h0[5:0], h1[10:0], 1'b0};
            end
            // Thumb call and jump: S:I1:I2:imm10:imm11:0.
            RELOC_THM_CALL, RELOC_THM_JUMP24: begin
                res.addend = {{7{s}}, s, i1, i2, h0[9:0], h1[10:0], 1'b0};
            end
            // Arm MOVW/MOVT: imm4:imm12.
            RELOC_MOVW_ABS_NC, RELOC_MOVT_ABS, RELOC_MOVW_PREL_NC,
            RELOC_MOVT_PREL, RELOC_MOVW_BREL_NC, RELOC_MOVT_BREL: begin
                imm16      = {w[19:16], w[11:0]};
                res.addend = {{16{imm16[15]}}, imm16};
            end
            // Thumb MOVW/MOVT: imm4:i:imm3:imm8.
            RELOC_THM_MOVW_ABS_NC, RELOC_THM_MOVT_ABS, RELOC_THM_MOVW_PREL_NC,
            RELOC_THM_MOVT_PREL, RELOC_THM_MOVW_BREL_NC,
            RELOC_THM_MOVT_BREL: begin
                imm16      = {h0[3:0], h0[10], h1[14:12], h1[7:0]};
                res.addend = {{16{imm16[15]}}, imm16};
            end
            // The group relocations for ALU instructions have no rule.
            RELOC_ALU_PC_G0_NC, RELOC_ALU_PC_G0, RELOC_ALU_PC_G1_NC,
            RELOC_ALU_PC_G1, RELOC_ALU_PC_G2: begin
                res.handled = 1'b0;
            end
            // Arm LDR: imm12, the U bit selects the sign.
            RELOC_LDR_PC_G0, RELOC_LDR_PC_G1, RELOC_LDR_PC_G2: begin
                imm        = {20'd0, w[11:0]};
                res.addend = w[23] ? imm : (32'd0 - imm);
            end
            // Arm LDRD/LDRH style: split imm8, the U bit selects the sign.
            RELOC_LDRS_PC_G0, RELOC_LDRS_PC_G1, RELOC_LDRS_PC_G2: begin
                imm        = {24'd0, w[11:8], w[3:0]};
                res.addend = w[23] ? imm : (32'd0 - imm);
            end
            // Thumb ADR: the SUBW form negates the immediate.
            RELOC_THM_ALU_PREL_11_0: begin
                imm        = {20'd0, h0[10], h1[14:12], h1[7:0]};
                res.addend = (h0[7:4] != 4'd0) ? (32'd0 - imm) : imm;
            end
            // Thumb PC8: ((imm8 * 4 + 4) mod 1024) - 4.
            RELOC_THM_PC8: begin
                pc8        = {h0[7:0], 2'b00} + 10'd4;
                res.addend = {22'd0, pc8} - 32'd4;
            end
            // Thumb LDR literal: imm12, the U bit selects the sign.
            RELOC_THM_PC12: begin
                imm        = {20'd0, h1[11:0]};
                res.addend = h0[7] ? imm : (32'd0 - imm);
            end
            default: begin
                res.handled = 1'b0;
            end
        endcase
        return res;
    endfunction

endpackage

// ----- rtl/core/arm_reloc_addend_extract.sv -----
// ============================================================================
// arm_reloc_addend_extract: ARM ELF REL implicit addend decoder
// Decodes the signed implicit addend held at a relocation site from the
// relocation type and the 32-bit little-endian site word.
// ============================================================================
//
// Channel  | Dir | tdata                  | tuser
// ---------+-----+------------------------+-------------------
// s_       | in  | [31:0] site_word       | [7:0] kind
// m_       | out | [31:0] addend (signed) | [0] handled
//
// One request is taken per cycle while m_tready does not stall; its result is
// registered in the input register, then in the result register around one
// decode stage, before it is offered on m_.
// Reset (aresetn low at a clock edge) empties both stages.
// A stall on m_tready holds the result register; the input register still
// takes a request while it is empty or the result register moves on.
// ============================================================================
module arm_reloc_addend_extract
    import arae_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    // Request channel.
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [WORD_W-1:0]   s_tdata,   // [31:0] site_word
    input  logic [KIND_W-1:0]   s_tuser,   // [7:0] kind
    // Result channel.
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [ADDEND_W-1:0] m_tdata,   // [31:0] addend
    output logic                m_tuser    // [0] handled
);

    logic                in_valid_reg;
    logic [KIND_W-1:0]   in_kind_reg;
    logic [WORD_W-1:0]   in_word_reg;
    logic                out_valid_reg;
    logic [ADDEND_W-1:0] out_addend_reg;
    logic                out_handled_reg;
    addend_res_t         res_next;
    logic                out_load;
    logic                in_load;

    // Each stage moves on when the stage after it is free or draining.
    assign out_load = ~out_valid_reg | m_tready;
    assign in_load  = ~in_valid_reg | out_load;
    assign s_tready = in_load;

    // Decode of the registered request.
    assign res_next = decode_addend(in_kind_reg, in_word_reg);

    // Stage valid flags.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (in_load) begin
                in_valid_reg <= s_tvalid;
            end
            if (out_load) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    // Input payload register.
    always_ff @(posedge aclk) begin
        if (in_load && s_tvalid) begin
            in_kind_reg <= s_tuser;
            in_word_reg <= s_tdata;
        end
    end

    // Result payload register.
    always_ff @(posedge aclk) begin
        if (out_load && in_valid_reg) begin
            out_addend_reg  <= res_next.addend;
            out_handled_reg <= res_next.handled;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_addend_reg;
    assign m_tuser  = out_handled_reg;

endmodule

// ----- tb/arm_reloc_addend_extract_tb.sv -----
`timescale 1ns / 100ps
// ============================================================================
// arm_reloc_addend_extract_tb: self-checking bench for the addend decoder
// Sends directed and random (relocation type, site word) requests through
// the stream input. A bench-side decoder predicts each addend. A monitor
// compares every result, in order, with its prediction. Both sides idle in
// random bursts, except in calm stretches and at the tail of the run.
// ============================================================================
module arm_reloc_addend_extract_tb;
    import arae_pkg::*;

    // Type numbers outside the ABI list, used to probe the fallback path.
    localparam kind_t KIND_UNUSED_LO = 8'd0;
    localparam kind_t KIND_UNUSED_HI = 8'd255;

    localparam int unsigned RANDOM_REQS = 1300;
    localparam int unsigned TAIL_REQS   = 150;

    typedef struct packed {
        kind_t kind;
        word_t site;
    } reloc_req_t;

    typedef struct packed {
        logic [ADDEND_W-1:0] addend;
        logic                handled;
    } addend_exp_t;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [WORD_W-1:0]   s_tdata  = '0;    // [31:0] site_word
    logic [KIND_W-1:0]   s_tuser  = '0;    // [7:0] kind
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [ADDEND_W-1:0] m_tdata;          // [31:0] addend
    logic                m_tuser;          // [0] handled

    reloc_req_t  reloc_queue[$];
    addend_exp_t addend_expect[$];

    logic        req_taken  = 1'b0;
    int unsigned stim_total = 0;
    int unsigned sent_cnt   = 0;
    int unsigned result_cnt = 0;
    int unsigned src_gap    = 0;
    int unsigned snk_gap    = 0;
    int unsigned mismatch_cnt = 0;

    // Every type number that the ABI list names, the ALU group included.
    kind_t known_kinds [0:53] = '{
        RELOC_PC24, RELOC_ABS32, RELOC_REL32, RELOC_LDR_PC_G0, RELOC_SBREL32,
        RELOC_THM_CALL, RELOC_THM_PC8, RELOC_TLS_DTPMOD32, RELOC_TLS_DTPOFF32,
        RELOC_TLS_TPOFF32, RELOC_GLOB_DAT, RELOC_RELATIVE, RELOC_GOTOFF32,
        RELOC_BASE_PREL, RELOC_GOT_BREL, RELOC_PLT32, RELOC_CALL, RELOC_JUMP24,
        RELOC_THM_JUMP24, RELOC_TARGET1, RELOC_PREL31, RELOC_MOVW_ABS_NC,
        RELOC_MOVT_ABS, RELOC_MOVW_PREL_NC, RELOC_MOVT_PREL,
        RELOC_THM_MOVW_ABS_NC, RELOC_THM_MOVT_ABS, RELOC_THM_MOVW_PREL_NC,
        RELOC_THM_MOVT_PREL, RELOC_THM_JUMP19, RELOC_THM_ALU_PREL_11_0,
        RELOC_THM_PC12, RELOC_ALU_PC_G0_NC, RELOC_ALU_PC_G0, RELOC_ALU_PC_G1_NC,
        RELOC_ALU_PC_G1, RELOC_ALU_PC_G2, RELOC_LDR_PC_G1, RELOC_LDR_PC_G2,
        RELOC_LDRS_PC_G0, RELOC_LDRS_PC_G1, RELOC_LDRS_PC_G2,
        RELOC_MOVW_BREL_NC, RELOC_MOVT_BREL, RELOC_THM_MOVW_BREL_NC,
        RELOC_THM_MOVT_BREL, RELOC_GOT_PREL, RELOC_THM_JUMP11, RELOC_THM_JUMP8,
        RELOC_TLS_GD32, RELOC_TLS_LDM32, RELOC_TLS_LDO32, RELOC_TLS_IE32,
        RELOC_TLS_LE32
    };

    arm_reloc_addend_extract u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // 8 ns clock.
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Sign-extend the low w bits of v.
    function automatic logic [31:0] sext_from(input logic [31:0] v, input int unsigned w);
        logic signed [31:0] t;
        t = $signed(v << (32 - w));
        return t >>> (32 - w);
    endfunction

    // Bench-side decode of the implicit addend for one request.
    function automatic addend_exp_t predict_addend(input kind_t kind, input word_t site);
        logic [15:0] h0;
        logic [15:0] h1;
        logic        s;
        logic [31:0] imm;
        addend_exp_t r;
        h0        = site[15:0];
        h1        = site[31:16];
        s         = h0[10];
        r.addend  = 32'd0;
        r.handled = 1'b1;
        case (kind)
            RELOC_ABS32, RELOC_REL32, RELOC_SBREL32, RELOC_TLS_DTPMOD32,
            RELOC_TLS_DTPOFF32, RELOC_TLS_TPOFF32, RELOC_GLOB_DAT,
            RELOC_RELATIVE, RELOC_GOTOFF32, RELOC_BASE_PREL, RELOC_GOT_BREL,
            RELOC_TARGET1, RELOC_GOT_PREL, RELOC_TLS_GD32, RELOC_TLS_LDM32,
            RELOC_TLS_LDO32, RELOC_TLS_IE32, RELOC_TLS_LE32: begin
                r.addend = site;
            end
            RELOC_PREL31: begin
                r.addend = sext_from(site, 31);
            end
            RELOC_PC24, RELOC_PLT32, RELOC_CALL, RELOC_JUMP24: begin
                r.addend = sext_from({6'd0, site[23:0], 2'b00}, 26);
            end
            RELOC_THM_JUMP8: begin
                r.addend = sext_from({23'd0, h0[7:0], 1'b0}, 9);
            end
            RELOC_THM_JUMP11: begin
                r.addend = sext_from({20'd0, h0[10:0], 1'b0}, 12);
            end
            RELOC_THM_JUMP19: begin
                r.addend = sext_from({11'd0, s, h1[11], h1[13], h0[5:0],
                                      h1[10:0], 1'b0}, 21);
            end
            // The I bits are the J bits flipped when S is clear.
            RELOC_THM_CALL, RELOC_THM_JUMP24: begin
                r.addend = sext_from({7'd0, s, ~(h1[13] ^ s), ~(h1[11] ^ s),
                                      h0[9:0], h1[10:0], 1'b0}, 25);
            end
            RELOC_MOVW_ABS_NC, RELOC_MOVT_ABS, RELOC_MOVW_PREL_NC,
            RELOC_MOVT_PREL, RELOC_MOVW_BREL_NC, RELOC_MOVT_BREL: begin
                r.addend = sext_from({16'd0, site[19:16], site[11:0]}, 16);
            end
            RELOC_THM_MOVW_ABS_NC, RELOC_THM_MOVT_ABS, RELOC_THM_MOVW_PREL_NC,
            RELOC_THM_MOVT_PREL, RELOC_THM_MOVW_BREL_NC,
            RELOC_THM_MOVT_BREL: begin
                r.addend = sext_from({16'd0, h0[3:0], h0[10], h1[14:12], h1[7:0]}, 16);
            end
            RELOC_LDR_PC_G0, RELOC_LDR_PC_G1, RELOC_LDR_PC_G2: begin
                imm      = {20'd0, site[11:0]};
                r.addend = site[23] ? imm : -imm;
            end
            RELOC_LDRS_PC_G0, RELOC_LDRS_PC_G1, RELOC_LDRS_PC_G2: begin
                imm      = {24'd0, site[11:8], site[3:0]};
                r.addend = site[23] ? imm : -imm;
            end
            // Any bit in the first halfword's nibble 7:4 marks the SUBW form.
            RELOC_THM_ALU_PREL_11_0: begin
                imm      = {20'd0, h0[10], h1[14:12], h1[7:0]};
                r.addend = (h0[7:4] == 4'd0) ? imm : -imm;
            end
            RELOC_THM_PC8: begin
                imm      = {22'd0, h0[7:0], 2'b00} + 32'd4;
                r.addend = (imm & 32'h0000_03ff) - 32'd4;
            end
            RELOC_THM_PC12: begin
                imm      = {20'd0, h1[11:0]};
                r.addend = h0[7] ? imm : -imm;
            end
            default: begin
                // The ALU group and unknown types land here.
                r.handled = 1'b0;
            end
        endcase
        return r;
    endfunction

    // Stretches where neither side idles: the tail and one block in four.
    function automatic logic quiet_stretch(input int unsigned n);
        return (n + TAIL_REQS >= stim_total) || (((n / 80) % 4) == 3);
    endfunction

    task automatic push_req(input kind_t kind, input word_t site);
        reloc_req_t r;
        r.kind = kind;
        r.site = site;
        reloc_queue.push_back(r);
    endtask

    // Request driver: presents the next pending request, or idles in bursts.
    always @(negedge aclk) begin
        reloc_req_t nxt;
        if (aresetn && (!s_tvalid || req_taken)) begin
            if (src_gap != 0) begin
                src_gap = src_gap - 1;
                s_tvalid <= 1'b0;
            end else if (reloc_queue.size() == 0) begin
                s_tvalid <= 1'b0;
            end else if (!quiet_stretch(sent_cnt) && $urandom_range(0, 5) == 0) begin
                src_gap = $urandom_range(1, 19) - 1;
                s_tvalid <= 1'b0;
            end else begin
                nxt = reloc_queue.pop_front();
                s_tuser  <= nxt.kind;
                s_tdata  <= nxt.site;
                s_tvalid <= 1'b1;
                sent_cnt = sent_cnt + 1;
            end
        end
    end

    // Result side back-pressure in bursts.
    always @(negedge aclk) begin
        if (snk_gap != 0) begin
            snk_gap = snk_gap - 1;
            m_tready <= 1'b0;
        end else if (!quiet_stretch(result_cnt) && $urandom_range(0, 6) == 0) begin
            snk_gap = $urandom_range(1, 19) - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Monitor: checks each result against the oldest prediction, then
    // records the prediction for a request taken at this edge.
    always @(posedge aclk) begin
        addend_exp_t want;
        req_taken <= aresetn && s_tvalid && s_tready;
        if (aresetn && m_tvalid && m_tready) begin
            result_cnt = result_cnt + 1;
            if (addend_expect.size() == 0) begin
                mismatch_cnt = mismatch_cnt + 1;
                $display("%0t: unexpected result: expected none, actual addend=%h handled=%b",
                         $realtime, m_tdata, m_tuser);
            end else begin
                want = addend_expect.pop_front();
                if (m_tdata !== want.addend) begin
                    mismatch_cnt = mismatch_cnt + 1;
                    $display("%0t: addend mismatch: expected %h, actual %h",
                             $realtime, want.addend, m_tdata);
                end
                if (m_tuser !== want.handled) begin
                    mismatch_cnt = mismatch_cnt + 1;
                    $display("%0t: handled mismatch: expected %b, actual %b",
                             $realtime, want.handled, m_tuser);
                end
            end
        end
        if (aresetn && s_tvalid && s_tready) begin
            addend_expect.push_back(predict_addend(s_tuser, s_tdata));
        end
    end

    // Stimulus, reset and end of run.
    initial begin
        kind_t kind;
        word_t site;
        // Directed requests: field extremes and each decode form.
        push_req(RELOC_ABS32, 32'hffff_ffff);
        push_req(RELOC_PREL31, 32'h8000_0000);
        push_req(RELOC_PREL31, 32'h4000_0000);
        push_req(RELOC_PC24, 32'h0080_0000);
        push_req(RELOC_CALL, 32'hff7f_ffff);
        push_req(RELOC_THM_JUMP8, 32'h0000_0080);
        push_req(RELOC_THM_JUMP11, 32'h0000_0400);
        push_req(RELOC_THM_JUMP19, 32'h0000_0400);
        push_req(RELOC_THM_JUMP19, 32'hffff_ffff);
        push_req(RELOC_THM_CALL, 32'h0000_0000);
        push_req(RELOC_THM_JUMP24, 32'h2800_0400);
        push_req(RELOC_MOVW_ABS_NC, 32'h000f_0fff);
        push_req(RELOC_MOVT_BREL, 32'hfff7_0fff);
        push_req(RELOC_THM_MOVW_ABS_NC, 32'hffff_ffff);
        push_req(RELOC_THM_MOVT_BREL, 32'h0000_0000);
        push_req(RELOC_ALU_PC_G0_NC, 32'hffff_ffff);
        push_req(RELOC_ALU_PC_G2, 32'h1234_5678);
        push_req(RELOC_LDR_PC_G0, 32'h0000_0fff);
        push_req(RELOC_LDR_PC_G2, 32'h0080_0fff);
        push_req(RELOC_LDRS_PC_G1, 32'h0000_0f0f);
        push_req(RELOC_THM_ALU_PREL_11_0, 32'h70ff_04f0);
        push_req(RELOC_THM_ALU_PREL_11_0, 32'h70ff_0400);
        push_req(RELOC_THM_PC8, 32'h0000_00ff);
        push_req(RELOC_THM_PC8, 32'h0000_0000);
        push_req(RELOC_THM_PC12, 32'h0fff_0000);
        push_req(KIND_UNUSED_LO, 32'hffff_ffff);
        push_req(KIND_UNUSED_HI, 32'hffff_ffff);

        // Random requests: mostly listed types, some arbitrary type numbers.
        repeat (RANDOM_REQS) begin
            if ($urandom_range(0, 4) == 0)
                kind = kind_t'($urandom_range(0, 255));
            else
                kind = known_kinds[$urandom_range(0, $size(known_kinds) - 1)];
            case ($urandom_range(0, 4))
                0: site = $urandom & $urandom;
                1: site = $urandom | $urandom;
                2: begin
                    case ($urandom_range(0, 3))
                        0: site = 32'h0000_0000;
                        1: site = 32'hffff_ffff;
                        2: site = 32'h8000_0000;
                        default: site = 32'h7fff_ffff;
                    endcase
                end
                default: site = $urandom;
            endcase
            push_req(kind, site);
        end
        stim_total = reloc_queue.size();

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        while (reloc_queue.size() != 0 || s_tvalid || addend_expect.size() != 0)
            @(posedge aclk);
        repeat (10) @(posedge aclk);

        if (mismatch_cnt == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Run limit, far beyond the slowest correct run.
    initial begin
        #2000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/arae_pkg.sv
rtl/core/arm_reloc_addend_extract.sv
tb/arm_reloc_addend_extract_tb.sv
